// ===== hdl/dcd_pkg.sv =====
// Shared types and constants for the directed cycle detector.
// Holds the vertex mark codes and the sequencer state type; no dependencies.
`default_nettype none

package dcd_pkg;

    // Per-vertex search marks.
    typedef enum logic [1:0] {
        MARK_UNVISITED = 2'd0,
        MARK_ON_PATH   = 2'd1,
        MARK_DONE      = 2'd2
    } t_mark;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_ROOT_RD,
        S_ROOT_CHK,
        S_STEP,
        S_POP,
        S_EDGE,
        S_MARK,
        S_OUT,
        S_CLEAR
    } t_state;

    localparam int CFG_W = 11;
    localparam int FLD_W = 10;

endpackage

`default_nettype wire

// ===== hdl/directed_cycle_detector.sv =====
// Directed cycle detector top level: edge list storage and a DFS sequencer.
// Depends on dcd_pkg for mark codes and sequencer states.
//
// Usage: input items arrive on i_in_valid / o_in_stall. An item with command 0
// adds the edge edge_from -> edge_to: the list head of the source vertex is read
// and then rewritten. Edges with an endpoint at or above the vertex count, or
// beyond the edge store, are dropped and flagged. An item with command 1 runs a
// depth-first search from each vertex below the vertex count: it checks each
// root vertex, follows each edge and finishes each vertex in turn. Its result
// item appears on o_out_valid / i_out_stall. A clearing pass then resets list
// heads and marks, one entry a cycle; o_in_stall stays high until it is done.
// The same pass runs right after reset.
// The result is held in an output register, so the clearing pass and later
// edge loading go on while the receiver stalls; a further finish waits for
// the register to empty. The vertex_count register is written over the
// i_cfg_valid / o_cfg_ready port, which is always ready, and resets to one.
`default_nettype none

module directed_cycle_detector #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_command,
    input  wire logic [dcd_pkg::FLD_W-1:0] i_edge_from,
    input  wire logic [dcd_pkg::FLD_W-1:0] i_edge_to,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_has_cycle,
    output logic                           o_edges_dropped,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [dcd_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NW  = VW + 1;
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int ETW = EW + 1;
    localparam int CW  = (NW > dcd_pkg::CFG_W) ? NW : dcd_pkg::CFG_W;
    localparam logic [ETW-1:0] EMPTY = ETW'(MAX_EDGES);

    // Memories.
    logic [ETW-1:0] head_mem [MAX_VERTICES];
    logic [1:0]     mark_mem [MAX_VERTICES];
    logic [ETW-1:0] next_mem [MAX_EDGES];
    logic [VW-1:0]  tgt_mem  [MAX_EDGES];
    logic [VW-1:0]  stkv_mem [MAX_VERTICES];
    logic [ETW-1:0] stkc_mem [MAX_VERTICES];

    // Registers.
    dcd_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_vc;
    logic [NW-1:0]   r_root, n_root;
    logic [NW-1:0]   r_depth, n_depth;
    logic [VW-1:0]   r_top_v, n_top_v;
    logic [ETW-1:0]  r_top_c, n_top_c;
    logic [VW-1:0]   r_w, n_w;
    logic [VW-1:0]   r_from, n_from;
    logic [VW-1:0]   r_to, n_to;
    logic [ETW-1:0]  r_total, n_total;
    logic            r_drop, n_drop;
    logic            r_cyc, n_cyc;
    logic [VW-1:0]   r_clr, n_clr;
    logic            r_out_valid, n_out_valid;
    logic            r_has_cycle, n_has_cycle;
    logic            r_dropped, n_dropped;

    // Memory ports.
    logic           head_we, mark_we, edge_we, stk_we;
    logic [VW-1:0]  head_wa, head_ra, mark_wa, mark_ra, stk_wa, stk_ra;
    logic [ETW-1:0] head_wd, head_rd, next_rd;
    logic [1:0]     mark_wd, mark_rd;
    logic [EW-1:0]  edge_ra;
    logic [VW-1:0]  tgt_rd, stkv_rd;
    logic [ETW-1:0] stkc_rd;
    logic [ETW-1:0] n_top_c_save;

    logic [NW-1:0]  n_act;
    logic           in_acc, out_acc;
    logic           bad_edge;
    logic [NW-1:0]  depth_m1, depth_m2;

    // Active vertex count, saturated to the vertex capacity.
    assign n_act = (r_vc > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(r_vc);

    assign o_in_stall      = (r_state != dcd_pkg::S_IDLE);
    assign in_acc          = i_in_valid && !o_in_stall;
    assign out_acc         = r_out_valid && !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_has_cycle     = r_has_cycle;
    assign o_edges_dropped = r_dropped;
    assign o_cfg_ready     = 1'b1;

    assign bad_edge = (CW'(i_edge_from) >= CW'(n_act)) || (CW'(i_edge_to) >= CW'(n_act))
                   || (r_total == EMPTY);
    assign depth_m1 = r_depth - NW'(1);
    assign depth_m2 = r_depth - NW'(2);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= CW'(1);
        end else if (i_cfg_valid) begin
            r_vc <= CW'(i_cfg_data);
        end
    end

    // Control state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dcd_pkg::S_CLEAR;
            r_clr       <= '0;
            r_total     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_root      <= '0;
            r_cyc       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_total     <= n_total;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
            r_depth     <= n_depth;
            r_root      <= n_root;
            r_cyc       <= n_cyc;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_top_v     <= n_top_v;
        r_top_c     <= n_top_c;
        r_w         <= n_w;
        r_from      <= n_from;
        r_to        <= n_to;
        r_has_cycle <= n_has_cycle;
        r_dropped   <= n_dropped;
    end

    // Sequencer: next state and memory controls.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_total     = r_total;
        n_drop      = r_drop;
        n_out_valid = r_out_valid && !out_acc;
        n_depth     = r_depth;
        n_root      = r_root;
        n_cyc       = r_cyc;
        n_top_v     = r_top_v;
        n_top_c     = r_top_c;
        n_w         = r_w;
        n_from      = r_from;
        n_to        = r_to;
        n_has_cycle = r_has_cycle;
        n_dropped   = r_dropped;
        head_we     = 1'b0;
        head_wa     = r_from;
        head_wd     = r_total;
        head_ra     = VW'(i_edge_from);
        mark_we     = 1'b0;
        mark_wa     = r_top_v;
        mark_wd     = dcd_pkg::MARK_ON_PATH;
        mark_ra     = r_root[VW-1:0];
        edge_we     = 1'b0;
        edge_ra     = r_top_c[EW-1:0];
        stk_we      = 1'b0;
        stk_wa      = depth_m1[VW-1:0];
        stk_ra      = depth_m2[VW-1:0];

        unique case (r_state)
            dcd_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_command) begin
                        n_root  = '0;
                        n_cyc   = 1'b0;
                        n_state = dcd_pkg::S_ROOT_RD;
                    end else if (bad_edge) begin
                        n_drop = 1'b1;
                    end else begin
                        n_from  = VW'(i_edge_from);
                        n_to    = VW'(i_edge_to);
                        n_state = dcd_pkg::S_ADD;
                    end
                end
            end
            // Link the new edge in front of its source's list.
            dcd_pkg::S_ADD: begin
                head_we = 1'b1;
                edge_we = 1'b1;
                n_total = r_total + ETW'(1);
                n_state = dcd_pkg::S_IDLE;
            end
            // Fetch the mark and list head of the next root.
            dcd_pkg::S_ROOT_RD: begin
                head_ra = r_root[VW-1:0];
                if (r_root >= n_act) begin
                    n_state = dcd_pkg::S_OUT;
                end else begin
                    n_state = dcd_pkg::S_ROOT_CHK;
                end
            end
            dcd_pkg::S_ROOT_CHK: begin
                if (mark_rd == dcd_pkg::MARK_UNVISITED) begin
                    mark_we = 1'b1;
                    mark_wa = r_root[VW-1:0];
                    n_top_v = r_root[VW-1:0];
                    n_top_c = head_rd;
                    n_depth = NW'(1);
                    n_state = dcd_pkg::S_STEP;
                end else begin
                    n_root  = r_root + NW'(1);
                    n_state = dcd_pkg::S_ROOT_RD;
                end
            end
            // Finish the top vertex or fetch its next edge.
            dcd_pkg::S_STEP: begin
                if (r_top_c == EMPTY) begin
                    mark_we = 1'b1;
                    mark_wd = dcd_pkg::MARK_DONE;
                    n_depth = depth_m1;
                    if (r_depth == NW'(1)) begin
                        n_root  = r_root + NW'(1);
                        n_state = dcd_pkg::S_ROOT_RD;
                    end else begin
                        n_state = dcd_pkg::S_POP;
                    end
                end else begin
                    n_state = dcd_pkg::S_EDGE;
                end
            end
            dcd_pkg::S_POP: begin
                n_top_v = stkv_rd;
                n_top_c = stkc_rd;
                n_state = dcd_pkg::S_STEP;
            end
            // Advance the cursor and look up the edge's target.
            dcd_pkg::S_EDGE: begin
                n_top_c = next_rd;
                n_w     = tgt_rd;
                head_ra = tgt_rd;
                mark_ra = tgt_rd;
                n_state = dcd_pkg::S_MARK;
            end
            dcd_pkg::S_MARK: begin
                n_state = dcd_pkg::S_STEP;
                if (mark_rd == dcd_pkg::MARK_ON_PATH) begin
                    n_cyc   = 1'b1;
                    n_state = dcd_pkg::S_OUT;
                end else if (mark_rd == dcd_pkg::MARK_UNVISITED
                             && r_depth < NW'(MAX_VERTICES)) begin
                    mark_we = 1'b1;
                    mark_wa = r_w;
                    stk_we  = 1'b1;
                    n_top_v = r_w;
                    n_top_c = head_rd;
                    n_depth = r_depth + NW'(1);
                end
            end
            // Hand the result to the output register once it is free.
            dcd_pkg::S_OUT: begin
                if (!r_out_valid || out_acc) begin
                    n_out_valid = 1'b1;
                    n_has_cycle = r_cyc;
                    n_dropped   = r_drop;
                    n_drop      = 1'b0;
                    n_total     = '0;
                    n_depth     = '0;
                    n_clr       = '0;
                    n_state     = dcd_pkg::S_CLEAR;
                end
            end
            // Sweep list heads and marks back to empty and unvisited.
            dcd_pkg::S_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                head_wd = EMPTY;
                mark_we = 1'b1;
                mark_wa = r_clr;
                mark_wd = dcd_pkg::MARK_UNVISITED;
                n_clr   = r_clr + VW'(1);
                if (r_clr == VW'(MAX_VERTICES - 1)) begin
                    n_state = dcd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dcd_pkg::S_IDLE;
            end
        endcase
    end

    // List head memory.
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_wa] <= head_wd;
        end
        head_rd <= head_mem[head_ra];
    end

    // Vertex mark memory.
    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mark_mem[mark_wa] <= mark_wd;
        end
        mark_rd <= mark_mem[mark_ra];
    end

    // Edge link and target memories.
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            next_mem[r_total[EW-1:0]] <= head_rd;
            tgt_mem[r_total[EW-1:0]]  <= r_to;
        end
        next_rd <= next_mem[edge_ra];
        tgt_rd  <= tgt_mem[edge_ra];
    end

    // The cursor saved on a push is the one already advanced past this edge.
    assign n_top_c_save = r_top_c;

    // Path stack memory, holding all entries below the top.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stkv_mem[stk_wa] <= r_top_v;
            stkc_mem[stk_wa] <= n_top_c_save;
        end
        stkv_rd <= stkv_mem[stk_ra];
        stkc_rd <= stkc_mem[stk_ra];
    end

`ifndef SYNTHESIS
    // The path never grows past the vertex capacity.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= NW'(MAX_VERTICES))
        else $error("path depth above capacity");

    // The edge count never exceeds the store.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= EMPTY)
        else $error("edge count above capacity");

    // An accepted finish item holds off further input.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_command |=> o_in_stall)
        else $error("input taken during search");

    // A result only appears from the result hand-off state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == dcd_pkg::S_OUT))
        else $error("result outside hand-off");
`endif

endmodule

`default_nettype wire
